/* src/ultrasonic_range_kalman_filter_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef ULTRASONIC_RANGE_KALMAN_FILTER_MACROS_SVH
`define ULTRASONIC_RANGE_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define URKF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("urkf assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define URKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("urkf assertion failed");

`endif

/* src/urkf_pkg.sv */
// ----------------------------------------------------------------------------
// urkf_pkg
// Shared widths, constants, codes and controller/datapath types for the
// ultrasonic range Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package urkf_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int US_PER_CM = 58;
    localparam int ECHO_W    = 16;
    localparam int EST_W     = 27;               // Q11.16 cm
    localparam int COV_W     = FRAC_BITS + 8;    // Q8.16
    localparam int GAIN_W    = FRAC_BITS + 1;    // Q1.16, up to one inclusive
    localparam int DEN_W     = COV_W + 1;
    localparam int OUT_W     = 17;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    // Range conversion: multiply by a rounded-up reciprocal of US_PER_CM.
    // The shift leaves enough headroom that the quotient is exact for every
    // echo width shifted up by FRAC_BITS.
    localparam int RECIP_SHIFT = ECHO_W + FRAC_BITS + $clog2(US_PER_CM);
    localparam int RECIP_W     = ECHO_W + FRAC_BITS + 1;
    localparam int ZPROD_W     = ECHO_W + RECIP_W;
    localparam int Z_POS       = RECIP_SHIFT - FRAC_BITS;
    localparam logic [RECIP_W-1:0] Z_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(US_PER_CM - 1)) / 64'(US_PER_CM));

    // Serial divider for the gain
    localparam int DVD_W     = COV_W + FRAC_BITS;   // widest dividend
    localparam int G_ITER    = DVD_W;               // steps for the gain divide
    localparam int CNT_W     = $clog2(DVD_W + 1);

    // Product widths
    localparam int CORR_W    = GAIN_W + EST_W;
    localparam int CPROD_W   = COV_W + GAIN_W;
    localparam int SCALE_W   = EST_W + 7;

    localparam logic [GAIN_W-1:0] FX_ONE  = GAIN_W'(1) << FRAC_BITS;
    localparam logic [COV_W-1:0]  COV_MAX = '1;

    // Register reset values
    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST = CFG_W'(655);
    localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = CFG_W'(65536);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME,
        S_GLOAD,
        S_GDIV,
        S_GCAP,
        S_CORR,
        S_UPD,
        S_SCALE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_z;     // capture the range of the accepted echo
        logic load_g;     // start gain divide
        logic step;       // advance divider one bit
        logic prime;      // prime estimate, form p
        logic gain_zero;  // zero denominator: gain is zero
        logic gain_cap;   // capture gain quotient
        logic corr;       // form both products
        logic upd;        // update estimate and covariance
        logic scale;      // scale estimate to hundredths
        logic out_load;   // load result register
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic den_zero;
        logic out_full;
    } t_stat;

endpackage

`default_nettype wire

/* src/urkf_div.sv */
// ----------------------------------------------------------------------------
// urkf_div
// Restoring divider, one quotient bit per step, used for the gain
// computation.
// ----------------------------------------------------------------------------
`default_nettype none

module urkf_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic                      i_step,
    input  wire logic [urkf_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [urkf_pkg::DEN_W-1:0] i_divisor,
    input  wire logic [urkf_pkg::CNT_W-1:0] i_count,
    output logic      [urkf_pkg::DVD_W-1:0] o_quot,
    output logic                           o_last
);
    import urkf_pkg::*;

    logic [DVD_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_dif;
    logic             fits;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        rem_dif = rem_sh - {1'b0, r_dvs};
        fits    = (rem_sh >= {1'b0, r_dvs});
    end

    // Control: step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (i_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Datapath: shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_step) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_quot = r_quo;
    assign o_last = (r_cnt == CNT_W'(1));

endmodule

`default_nettype wire

/* src/urkf_ctrl.sv */
// ----------------------------------------------------------------------------
// urkf_ctrl
// Sequencer of the filter step: range capture, priming, gain divide,
// correction, scaling and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module urkf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire urkf_pkg::t_stat i_stat,
    output urkf_pkg::t_cmd       o_cmd
);
    import urkf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_z = 1'b1;
                    n_state      = S_PRIME;
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = S_GLOAD;
            end
            S_GLOAD: begin
                if (i_stat.den_zero) begin
                    o_cmd.gain_zero = 1'b1;
                    n_state         = S_CORR;
                end else begin
                    o_cmd.load_g = 1'b1;
                    n_state      = S_GDIV;
                end
            end
            S_GDIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_GCAP;
                end
            end
            S_GCAP: begin
                o_cmd.gain_cap = 1'b1;
                n_state        = S_CORR;
            end
            S_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // hold until the previous result has been taken
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/urkf_dp.sv */
// ----------------------------------------------------------------------------
// urkf_dp
// Filter datapath: configuration registers, filter state, products and the
// result register, with the serial gain divider.
// ----------------------------------------------------------------------------
`default_nettype none

module urkf_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire urkf_pkg::t_cmd                i_cmd,
    output urkf_pkg::t_stat                    o_stat,
    input  wire logic [urkf_pkg::ECHO_W-1:0]    i_echo_us,
    input  wire logic                          i_cfg_we,
    input  wire logic [urkf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [urkf_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [urkf_pkg::OUT_W-1:0]     o_distance_hundredths
);
    import urkf_pkg::*;

    logic [CFG_W-1:0]   r_q;
    logic [CFG_W-1:0]   r_r;
    logic [EST_W-1:0]   r_est;
    logic [COV_W-1:0]   r_cov;
    logic               r_primed;
    logic [EST_W-1:0]   r_z;
    logic [COV_W-1:0]   r_p;
    logic [GAIN_W-1:0]  r_gain;
    logic [CORR_W-1:0]  r_corr;
    logic               r_up;
    logic [CPROD_W-1:0] r_cprod;
    logic [SCALE_W-1:0] r_oprod;
    logic [OUT_W-1:0]   r_out;
    logic               r_out_valid;

    logic [DVD_W-1:0]   div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic [CNT_W-1:0]   div_count;
    logic [DVD_W-1:0]   div_quot;
    logic               div_last;

    logic [ZPROD_W-1:0] z_prod;
    logic [EST_W-1:0]   z_new;
    logic [COV_W:0]     p_sum;
    logic [DEN_W-1:0]   denom;
    logic               z_ge;
    logic [EST_W-1:0]   diff;
    logic [EST_W-1:0]   delta;

    // Divider operands for the gain divide
    always_comb begin
        denom        = {1'b0, r_p} + {1'b0, r_r};
        div_dividend = {r_p, FRAC_BITS'(0)};
        div_divisor  = denom;
        div_count    = CNT_W'(G_ITER);
    end

    urkf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.load_g),
        .i_step     (i_cmd.step),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_count    (div_count),
        .o_quot     (div_quot),
        .o_last     (div_last)
    );

    // Step arithmetic; the range divide is a reciprocal multiply
    always_comb begin
        z_prod = ZPROD_W'(i_echo_us) * ZPROD_W'(Z_RECIP);
        z_new  = z_prod[Z_POS +: EST_W];
        p_sum  = {1'b0, r_cov} + {1'b0, r_q};
        z_ge   = (r_z >= r_est);
        diff   = z_ge ? (r_z - r_est) : (r_est - r_z);
        delta  = r_corr[FRAC_BITS +: EST_W];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= PROCESS_NOISE_RST;
            r_r <= MEASURE_NOISE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_NOISE: r_q <= i_cfg_data;
                CFG_MEASURE_NOISE: r_r <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est    <= '0;
            r_cov    <= '0;
            r_primed <= 1'b0;
        end else if (i_cmd.prime) begin
            // first sample seeds the estimate
            if (!r_primed) begin
                r_est <= r_z;
            end
            r_primed <= 1'b1;
        end else if (i_cmd.upd) begin
            r_est <= r_up ? (r_est + delta) : (r_est - delta);
            r_cov <= r_cprod[FRAC_BITS +: COV_W];
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_z) begin
            r_z <= z_new;
        end
        if (i_cmd.prime) begin
            // saturate the predicted covariance
            r_p <= p_sum[COV_W] ? COV_MAX : p_sum[COV_W-1:0];
        end
        if (i_cmd.gain_zero) begin
            r_gain <= '0;
        end else if (i_cmd.gain_cap) begin
            r_gain <= div_quot[GAIN_W-1:0];
        end
        if (i_cmd.corr) begin
            r_up    <= z_ge;
            r_corr  <= CORR_W'(r_gain) * CORR_W'(diff);
            r_cprod <= CPROD_W'(r_p) * CPROD_W'(FX_ONE - r_gain);
        end
        if (i_cmd.scale) begin
            r_oprod <= SCALE_W'(r_est) * SCALE_W'(100);
        end
        if (i_cmd.out_load) begin
            r_out <= r_oprod[FRAC_BITS +: OUT_W];
        end
    end

    // Result valid: set on load, drop when the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.div_last = div_last;
        o_stat.den_zero = (denom == '0);
        o_stat.out_full = r_out_valid;
    end

    assign o_out_valid           = r_out_valid;
    assign o_distance_hundredths = r_out;

endmodule

`default_nettype wire

/* src/ultrasonic_range_kalman_filter.sv */
// ----------------------------------------------------------------------------
// ultrasonic_range_kalman_filter
// Echo width to distance conversion followed by a scalar Kalman filter.
// ----------------------------------------------------------------------------
// Each echo width (us) is divided by 58 into Q11.16 cm with a reciprocal
// multiply at acceptance and smoothed by a constant-model scalar Kalman
// filter; the result is the estimate in 0.01 cm. One transaction is processed
// at a time: after the accepting edge come priming, divider load, 40 steps of
// a serial divider for the gain, gain capture, correction, update, scaling
// and result load, after which the result becomes valid. A zero gain
// denominator skips the gain divide and gain capture. The next input is
// accepted as soon as the result is loaded, even while that result waits in
// the output register; a result not yet taken holds the next one in its
// final cycle. Configuration writes take effect at once and must only occur
// while the block is idle.
`default_nettype none

module ultrasonic_range_kalman_filter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [urkf_pkg::ECHO_W-1:0]    i_echo_us,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [urkf_pkg::OUT_W-1:0]     o_distance_hundredths,
    input  wire logic                          i_cfg_we,
    input  wire logic [urkf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [urkf_pkg::CFG_W-1:0]     i_cfg_data
);
    import urkf_pkg::*;

`include "ultrasonic_range_kalman_filter_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    urkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    urkf_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_echo_us             (i_echo_us),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_distance_hundredths (o_distance_hundredths)
    );

    // Busy after an accepted transaction
    `URKF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // Never overwrite a result that has not been taken
    `URKF_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !stat.out_full)
    // Divider gets at most one of load and step at a time
    `URKF_ASSERT_IMPL(a_div_cmd_excl, 1'b1, $onehot0({cmd.load_g, cmd.step}))

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ultrasonic range Kalman filter. Echo widths go
// in over a valid/ready channel with random gaps, and results come back under
// random backpressure. An in-bench fixed-point copy of the filter predicts
// every filtered distance. Directed cases come first: field extremes, the
// first sample, a gain of one, a zero gain denominator and covariance
// saturation. Random tracking sequences follow, under several noise settings.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import urkf_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned IDLE_GUARD    = 8;
    localparam int unsigned END_GUARD     = 100;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 123;
    localparam int unsigned IDLE_PERCENT  = 17;
    localparam logic [CFG_W-1:0] NOISE_MAX = '1;

    typedef struct {
        logic [ECHO_W-1:0] echo;
        logic [OUT_W-1:0]  distance;
    } t_range_result;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ECHO_W-1:0]    i_echo_us = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [OUT_W-1:0]     o_distance_hundredths;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_PROCESS_NOISE;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Filter state and register copies
    logic [EST_W-1:0]     filt_estimate;
    logic [COV_W-1:0]     filt_covariance;
    logic                 filt_primed;
    logic [CFG_W-1:0]     cfg_process_noise;
    logic [CFG_W-1:0]     cfg_measure_noise;

    t_range_result        pending_ranges[$];
    t_range_result        oldest_range;
    int unsigned          error_count = 0;
    int unsigned          cycle_count = 0;
    logic                 steady_flow = 1'b0;

    ultrasonic_range_kalman_filter uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_echo_us             (i_echo_us),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_distance_hundredths (o_distance_hundredths),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel at random, except during a steady stretch
    always @(negedge i_clk) begin
        i_out_ready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < 100) begin
            $display("[%0t ns] MISMATCH: %s", $time, what);
        end
        error_count++;
    endtask

    // Compare each result transaction with the oldest pending distance
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_ranges.size() == 0) begin
                report_mismatch($sformatf("distance %0d arrived with no transaction pending",
                                          o_distance_hundredths));
            end else begin
                oldest_range = pending_ranges.pop_front();
                if (o_distance_hundredths !== oldest_range.distance) begin
                    report_mismatch($sformatf("echo %0d: distance %0d, predicted %0d",
                                              oldest_range.echo, o_distance_hundredths,
                                              oldest_range.distance));
                end
            end
        end
    end

    task automatic clear_filter_state();
        filt_estimate     = '0;
        filt_covariance   = '0;
        filt_primed       = 1'b0;
        cfg_process_noise = PROCESS_NOISE_RST;
        cfg_measure_noise = MEASURE_NOISE_RST;
    endtask

    // Advance the filter copy by one echo and return the filtered distance
    task automatic advance_range_filter(input logic [ECHO_W-1:0] echo,
                                        output logic [OUT_W-1:0] distance);
        logic [31:0]                range_fx;
        logic [EST_W-1:0]           range_cm;
        logic [COV_W:0]             cov_sum;
        logic [COV_W-1:0]           cov_pred;
        logic [COV_W:0]             gain_den;
        logic [COV_W+FRAC_BITS:0]   gain_quo;
        logic [GAIN_W-1:0]          gain;
        logic [EST_W-1:0]           residual;
        logic [GAIN_W+EST_W-1:0]    correction;
        logic [COV_W+GAIN_W-1:0]    cov_prod;
        logic [EST_W+6:0]           scaled;

        range_fx = (32'(echo) << FRAC_BITS) / 32'(US_PER_CM);
        range_cm = range_fx[EST_W-1:0];

        // Prime on the first sample
        if (!filt_primed) begin
            filt_estimate = range_cm;
            filt_primed   = 1'b1;
        end

        // Predict covariance, saturating at its maximum
        cov_sum  = filt_covariance + cfg_process_noise;
        cov_pred = (cov_sum > COV_MAX) ? COV_MAX : cov_sum[COV_W-1:0];

        // Gain is zero when the denominator is zero
        gain_den = cov_pred + cfg_measure_noise;
        if (gain_den == '0) begin
            gain = '0;
        end else begin
            gain_quo = ((COV_W+FRAC_BITS+1)'(cov_pred) << FRAC_BITS) / gain_den;
            gain     = (gain_quo > FX_ONE) ? FX_ONE : gain_quo[GAIN_W-1:0];
        end

        // Move toward the measurement, truncating the correction magnitude
        if (range_cm >= filt_estimate) begin
            residual      = range_cm - filt_estimate;
            correction    = gain * residual;
            filt_estimate = filt_estimate + EST_W'(correction >> FRAC_BITS);
        end else begin
            residual      = filt_estimate - range_cm;
            correction    = gain * residual;
            filt_estimate = filt_estimate - EST_W'(correction >> FRAC_BITS);
        end

        cov_prod        = cov_pred * (FX_ONE - gain);
        filt_covariance = COV_W'(cov_prod >> FRAC_BITS);

        scaled   = filt_estimate * 7'd100;
        distance = OUT_W'(scaled >> FRAC_BITS);
    endtask

    // Send one echo transaction, with a random hold-off ahead of it outside a steady stretch
    task automatic send_echo(input logic [ECHO_W-1:0] echo);
        logic [OUT_W-1:0] distance;

        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_echo_us  = echo;
        do @(posedge i_clk); while (!o_in_ready);
        advance_range_filter(echo, distance);
        pending_ranges.push_back('{echo: echo, distance: distance});
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_for_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_PROCESS_NOISE) begin
            cfg_process_noise = value;
        end else if (index == CFG_MEASURE_NOISE) begin
            cfg_measure_noise = value;
        end
    endtask

    task automatic set_noise(input logic [CFG_W-1:0] q_noise, input logic [CFG_W-1:0] r_noise);
        wait_for_idle();
        write_register(CFG_PROCESS_NOISE, q_noise);
        write_register(CFG_MEASURE_NOISE, r_noise);
    endtask

    // Spread noise values over many magnitudes, extremes included
    function automatic logic [CFG_W-1:0] pick_noise();
        case ($urandom_range(5))
            0:       return '0;
            1:       return NOISE_MAX;
            2:       return CFG_W'($urandom);
            3:       return CFG_W'($urandom_range(4095));
            4:       return CFG_W'(1) << $urandom_range(CFG_W-1);
            default: return CFG_W'($urandom_range(1 << 20));
        endcase
    endfunction

    // First sample, field extremes and a steady target under reset noise
    task automatic test_reset_and_extremes();
        logic [ECHO_W-1:0] widths [14] = '{
            16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd58, 16'd1, 16'd57, 16'd59,
            16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'd5800, 16'd5800
        };
        foreach (widths[k]) begin
            send_echo(widths[k]);
        end
    endtask

    // Gain of one clears the covariance, then a zero denominator freezes it
    task automatic test_gain_one_and_zero_denominator();
        set_noise(PROCESS_NOISE_RST, '0);
        send_echo(16'd3000);
        send_echo(16'd1200);
        set_noise('0, '0);
        send_echo(16'hFFFF);
        send_echo(16'd0);
        send_echo(16'd17);
    endtask

    // Saturate the predicted covariance
    task automatic test_covariance_saturation();
        set_noise(NOISE_MAX, NOISE_MAX);
        send_echo(16'd0);
        send_echo(16'hFFFF);
        send_echo(16'd30000);
        send_echo(16'd30001);
        set_noise(NOISE_MAX, '0);
        send_echo(16'd100);
        send_echo(16'hFFFF);
    endtask

    // Track a wandering target with jitter, mixed with random outliers
    task automatic test_random_tracking();
        int unsigned       n;
        int                jitter;
        int                sample;
        logic [ECHO_W-1:0] target;

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       set_noise(NOISE_MAX, '0);
                1:       set_noise('0, NOISE_MAX);
                2:       set_noise(PROCESS_NOISE_RST, MEASURE_NOISE_RST);
                default: set_noise(pick_noise(), pick_noise());
            endcase
            steady_flow = (phase == 2);
            target      = ECHO_W'($urandom_range(16'hFFFF));
            jitter      = 1 << $urandom_range(10);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Let the pipeline empty mid-phase now and then
                if (phase % 2 == 1 && n == PHASE_ITEMS / 2) begin
                    wait_for_idle();
                end
                if ($urandom_range(99) < 20) begin
                    send_echo(ECHO_W'($urandom_range(16'hFFFF)));
                end else begin
                    if ($urandom_range(99) < 5) begin
                        target = ECHO_W'($urandom_range(16'hFFFF));
                    end
                    sample = int'(target) + int'($urandom_range(2 * jitter)) - jitter;
                    if (sample < 0) begin
                        sample = 0;
                    end else if (sample > 65535) begin
                        sample = 65535;
                    end
                    send_echo(ECHO_W'(sample));
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        clear_filter_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_and_extremes();
        test_gain_one_and_zero_denominator();
        test_covariance_saturation();
        test_random_tracking();

        wait_for_idle();
        repeat (END_GUARD) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* ultrasonic_range_kalman_filter.f */
+incdir+src
src/urkf_pkg.sv
src/urkf_div.sv
src/urkf_ctrl.sv
src/urkf_dp.sv
src/ultrasonic_range_kalman_filter.sv
tb/sv/testbench.sv
